/* src/assert_macros.svh */
// Assertion shorthands used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_AFTER(label, clk, rst, ante, n, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
      else $error("delayed check failed");

// The condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

/* src/qvr_pkg.sv */
package qvr_pkg;

   // Register stages between an accepted item and its result strobe.
   localparam int unsigned LATENCY = 4;

endpackage

/* src/quaternion_vector_rotate_unit.sv */
// Quaternion vector rotation unit. Each item accepted (start high while busy is
// low) carries a Q16.16 vector and a Q2.16 quaternion q, and returns the vector
// part of q * (v, 0) * conj(q), each component saturated to the vector range.
// q is used as given and is not normalized, so a non-unit quaternion scales the
// result by its squared magnitude. The unit is a four-stage pipeline of
// multiply and add-round stages: it takes one item in every clock cycle and
// shows the result on the rsp_ ports, marked by rsp_valid, when the item leaves
// the output register. Results leave in the order the items came in.
// busy is high only while reset is held, since the pipeline never has to hold
// an item back and the receiver takes every result in the cycle it appears.
module quaternion_vector_rotate_unit #(
   parameter int VEC_WIDTH  = 32,
   parameter int QUAT_WIDTH = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VEC_WIDTH-1:0]  req_vec_x,
   input  logic signed [VEC_WIDTH-1:0]  req_vec_y,
   input  logic signed [VEC_WIDTH-1:0]  req_vec_z,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_x,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_y,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_z,
   input  logic signed [QUAT_WIDTH-1:0] req_quat_w,
   output logic                         rsp_valid,
   output logic signed [VEC_WIDTH-1:0]  rsp_rot_x,
   output logic signed [VEC_WIDTH-1:0]  rsp_rot_y,
   output logic signed [VEC_WIDTH-1:0]  rsp_rot_z
);
   import qvr_pkg::*;

   // Quaternion components carry two integer bits; the rest are fraction.
   localparam int QF  = QUAT_WIDTH - 2;
   // Width of a first-half product and of its three-term sum (with headroom
   // for the rounding constant).
   localparam int PA  = VEC_WIDTH + QUAT_WIDTH;
   localparam int SA  = PA + 2;
   // Intermediate quaternion r = q * v after rounding; its magnitude stays
   // within six times the vector range.
   localparam int RW  = SA - QF;
   // Second-half product, its four-term sum and the rounded result.
   localparam int PB  = RW + QUAT_WIDTH;
   localparam int SB  = PB + 2;
   localparam int OW  = SB - QF;

   // Round half up by QF bits on a first-half sum.
   function automatic logic signed [RW-1:0] round_a(input logic signed [SA-1:0] s);
      logic signed [SA-1:0] t;
      t = s + {{(SA-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
      return t[SA-1:QF];
   endfunction

   // Round half up by QF bits on a second-half sum.
   function automatic logic signed [OW-1:0] round_b(input logic signed [SB-1:0] s);
      logic signed [SB-1:0] t;
      t = s + {{(SB-QF){1'b0}}, 1'b1, {(QF-1){1'b0}}};
      return t[SB-1:QF];
   endfunction

   // Clamp a rounded component to the signed vector range.
   function automatic logic signed [VEC_WIDTH-1:0] saturate(
      input logic signed [OW-1:0] v
   );
      logic fits;
      fits = (&v[OW-1:VEC_WIDTH-1]) || !(|v[OW-1:VEC_WIDTH-1]);
      if (fits) begin
         return v[VEC_WIDTH-1:0];
      end else if (v[OW-1]) begin
         return {1'b1, {(VEC_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(VEC_WIDTH-1){1'b1}}};
      end
   endfunction

   // ------------------------------------------------------------------
   // Handshake. Nothing downstream can stall, so an item is refused only
   // while reset is held.
   // ------------------------------------------------------------------
   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // One valid bit per stage travels alongside the data.
   logic [LATENCY-1:0] valid_ff;
   logic [LATENCY-1:0] valid_in;
   assign valid_in = {valid_ff[LATENCY-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: the twelve products of r = q * (v, 0). Every product is exact.
   // ------------------------------------------------------------------
   logic signed [PA-1:0] p_wvx_in, p_yvz_in, p_zvy_in;
   logic signed [PA-1:0] p_wvy_in, p_xvz_in, p_zvx_in;
   logic signed [PA-1:0] p_wvz_in, p_xvy_in, p_yvx_in;
   logic signed [PA-1:0] p_xvx_in, p_yvy_in, p_zvz_in;
   logic signed [PA-1:0] p_wvx_ff, p_yvz_ff, p_zvy_ff;
   logic signed [PA-1:0] p_wvy_ff, p_xvz_ff, p_zvx_ff;
   logic signed [PA-1:0] p_wvz_ff, p_xvy_ff, p_yvx_ff;
   logic signed [PA-1:0] p_xvx_ff, p_yvy_ff, p_zvz_ff;
   logic signed [QUAT_WIDTH-1:0] q1_x_ff, q1_y_ff, q1_z_ff, q1_w_ff;

   assign p_wvx_in = PA'(req_quat_w) * PA'(req_vec_x);
   assign p_yvz_in = PA'(req_quat_y) * PA'(req_vec_z);
   assign p_zvy_in = PA'(req_quat_z) * PA'(req_vec_y);
   assign p_wvy_in = PA'(req_quat_w) * PA'(req_vec_y);
   assign p_xvz_in = PA'(req_quat_x) * PA'(req_vec_z);
   assign p_zvx_in = PA'(req_quat_z) * PA'(req_vec_x);
   assign p_wvz_in = PA'(req_quat_w) * PA'(req_vec_z);
   assign p_xvy_in = PA'(req_quat_x) * PA'(req_vec_y);
   assign p_yvx_in = PA'(req_quat_y) * PA'(req_vec_x);
   assign p_xvx_in = PA'(req_quat_x) * PA'(req_vec_x);
   assign p_yvy_in = PA'(req_quat_y) * PA'(req_vec_y);
   assign p_zvz_in = PA'(req_quat_z) * PA'(req_vec_z);

   always_ff @(posedge clock) begin
      p_wvx_ff <= p_wvx_in;
      p_yvz_ff <= p_yvz_in;
      p_zvy_ff <= p_zvy_in;
      p_wvy_ff <= p_wvy_in;
      p_xvz_ff <= p_xvz_in;
      p_zvx_ff <= p_zvx_in;
      p_wvz_ff <= p_wvz_in;
      p_xvy_ff <= p_xvy_in;
      p_yvx_ff <= p_yvx_in;
      p_xvx_ff <= p_xvx_in;
      p_yvy_ff <= p_yvy_in;
      p_zvz_ff <= p_zvz_in;
      q1_x_ff  <= req_quat_x;
      q1_y_ff  <= req_quat_y;
      q1_z_ff  <= req_quat_z;
      q1_w_ff  <= req_quat_w;
   end

   // ------------------------------------------------------------------
   // Stage 2: sum and round each component of r. The real part of r is
   // minus the dot product of the vector with the quaternion's axis.
   // r keeps its full width here; only the final result saturates.
   // ------------------------------------------------------------------
   logic signed [RW-1:0] r_x_in, r_y_in, r_z_in, r_w_in;
   logic signed [RW-1:0] r_x_ff, r_y_ff, r_z_ff, r_w_ff;
   logic signed [QUAT_WIDTH-1:0] q2_x_ff, q2_y_ff, q2_z_ff, q2_w_ff;

   assign r_x_in = round_a(SA'(p_wvx_ff) + SA'(p_yvz_ff) - SA'(p_zvy_ff));
   assign r_y_in = round_a(SA'(p_wvy_ff) - SA'(p_xvz_ff) + SA'(p_zvx_ff));
   assign r_z_in = round_a(SA'(p_wvz_ff) + SA'(p_xvy_ff) - SA'(p_yvx_ff));
   assign r_w_in = round_a(-SA'(p_xvx_ff) - SA'(p_yvy_ff) - SA'(p_zvz_ff));

   always_ff @(posedge clock) begin
      r_x_ff  <= r_x_in;
      r_y_ff  <= r_y_in;
      r_z_ff  <= r_z_in;
      r_w_ff  <= r_w_in;
      q2_x_ff <= q1_x_ff;
      q2_y_ff <= q1_y_ff;
      q2_z_ff <= q1_z_ff;
      q2_w_ff <= q1_w_ff;
   end

   // ------------------------------------------------------------------
   // Stage 3: the twelve products of r * conj(q) that feed the vector part.
   // The conjugate's signs are folded into the sums of stage 4.
   // ------------------------------------------------------------------
   logic signed [PB-1:0] b_wx_in, b_xw_in, b_yz_in, b_zy_in;
   logic signed [PB-1:0] b_wy_in, b_xz_in, b_yw_in, b_zx_in;
   logic signed [PB-1:0] b_wz_in, b_xy_in, b_yx_in, b_zw_in;
   logic signed [PB-1:0] b_wx_ff, b_xw_ff, b_yz_ff, b_zy_ff;
   logic signed [PB-1:0] b_wy_ff, b_xz_ff, b_yw_ff, b_zx_ff;
   logic signed [PB-1:0] b_wz_ff, b_xy_ff, b_yx_ff, b_zw_ff;

   // Names read as r component, then q component.
   assign b_wx_in = PB'(r_w_ff) * PB'(q2_x_ff);
   assign b_xw_in = PB'(r_x_ff) * PB'(q2_w_ff);
   assign b_yz_in = PB'(r_y_ff) * PB'(q2_z_ff);
   assign b_zy_in = PB'(r_z_ff) * PB'(q2_y_ff);
   assign b_wy_in = PB'(r_w_ff) * PB'(q2_y_ff);
   assign b_xz_in = PB'(r_x_ff) * PB'(q2_z_ff);
   assign b_yw_in = PB'(r_y_ff) * PB'(q2_w_ff);
   assign b_zx_in = PB'(r_z_ff) * PB'(q2_x_ff);
   assign b_wz_in = PB'(r_w_ff) * PB'(q2_z_ff);
   assign b_xy_in = PB'(r_x_ff) * PB'(q2_y_ff);
   assign b_yx_in = PB'(r_y_ff) * PB'(q2_x_ff);
   assign b_zw_in = PB'(r_z_ff) * PB'(q2_w_ff);

   always_ff @(posedge clock) begin
      b_wx_ff <= b_wx_in;
      b_xw_ff <= b_xw_in;
      b_yz_ff <= b_yz_in;
      b_zy_ff <= b_zy_in;
      b_wy_ff <= b_wy_in;
      b_xz_ff <= b_xz_in;
      b_yw_ff <= b_yw_in;
      b_zx_ff <= b_zx_in;
      b_wz_ff <= b_wz_in;
      b_xy_ff <= b_xy_in;
      b_yx_ff <= b_yx_in;
      b_zw_ff <= b_zw_in;
   end

   // ------------------------------------------------------------------
   // Stage 4: sum, round and saturate into the output register. The real
   // part of the product is not needed and is never formed.
   // ------------------------------------------------------------------
   logic signed [VEC_WIDTH-1:0] rot_x_in, rot_y_in, rot_z_in;
   logic signed [VEC_WIDTH-1:0] rot_x_ff, rot_y_ff, rot_z_ff;

   assign rot_x_in = saturate(round_b(
      -SB'(b_wx_ff) + SB'(b_xw_ff) - SB'(b_yz_ff) + SB'(b_zy_ff)));
   assign rot_y_in = saturate(round_b(
      -SB'(b_wy_ff) + SB'(b_xz_ff) + SB'(b_yw_ff) - SB'(b_zx_ff)));
   assign rot_z_in = saturate(round_b(
      -SB'(b_wz_ff) - SB'(b_xy_ff) + SB'(b_yx_ff) + SB'(b_zw_ff)));

   always_ff @(posedge clock) begin
      rot_x_ff <= rot_x_in;
      rot_y_ff <= rot_y_in;
      rot_z_ff <= rot_z_in;
   end

   assign rsp_valid = valid_ff[LATENCY-1];
   assign rsp_rot_x = rot_x_ff;
   assign rsp_rot_y = rot_y_ff;
   assign rsp_rot_z = rot_z_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   logic quat_zero;
   assign quat_zero = (req_quat_x == '0) && (req_quat_y == '0) &&
                      (req_quat_z == '0) && (req_quat_w == '0);

`include "assert_macros.svh"

   // Every accepted item produces its strobe after the full pipeline depth.
   `ASSERT_AFTER(a_item_emerges, clock, reset, accept, 4, rsp_valid)
   // No strobe appears without an item accepted that many cycles earlier.
   `ASSERT_NEVER(a_no_phantom, clock, reset, rsp_valid && !$past(accept, LATENCY))
   // A zero quaternion must rotate any vector to zero.
   `ASSERT_IMPLIES(a_zero_quat, clock, reset, rsp_valid && $past(accept && quat_zero, LATENCY), (rsp_rot_x == '0) && (rsp_rot_y == '0) && (rsp_rot_z == '0))

endmodule
